[src/srlc_pkg.sv]
// Shared types, codes, widths and the tanh table generator for the lag corrector.
package srlc_pkg;

    localparam int TANH_ENTRIES_DEF = 256;
    localparam int DWELL_BITS_DEF   = 24;

    localparam int CMD_W       = 2;
    localparam int LAG_W       = 20;
    localparam int MAG_W       = 20;
    localparam int CORR_W      = 16;
    localparam int CODE_W      = 15;
    localparam int DWELL_OUT_W = 24;
    localparam int STATUS_W    = 2;
    localparam int THR_W       = 19;
    localparam int SCALE_W     = 19;
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = 19;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CODE_W-1:0] CODE_MAX = 15'd32767;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LAG   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STARTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SYNCED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TANH_SCALE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_FRACTION = 2'd2;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 19'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 19'd25600;
    localparam logic [FRAC_W-1:0]  FRACTION_RESET  = 16'd58982;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_LOOKUP,
        ST_LOAD2,
        ST_CHECK,
        ST_DIV2,
        ST_FINISH
    } state_t;

    // Long division by shift and subtract, used only while building the table.
    function automatic longint unsigned div_floor(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table entry for Q30 argument z: tanh(8z) scaled to 32767, a zero entry raised to one.
    // Evaluated at elaboration only.
    function automatic logic [CODE_W-1:0] tanh_code(input longint unsigned z);
        longint unsigned one;
        longint unsigned t;
        longint unsigned s;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        one = 64'd1 << 30;
        t   = one;
        s   = one;
        for (int k = 1; k <= 20; k++)
        begin
            t = div_floor((t * z) >> 30, longint'(k));
            if ((k % 2) == 1)
                s = s - t;
            else
                s = s + t;
        end
        e = s;
        for (int k = 0; k < 4; k++)
            e = (e * e) >> 30;
        num = 64'd2 * 64'd32767 * (one - e) + (one + e);
        den = 64'd2 * (one + e);
        q   = div_floor(num, den);
        if (q == 64'd0)
            q = 64'd1;
        return q[CODE_W-1:0];
    endfunction

endpackage

[src/sample_rate_lag_corrector.sv]
// Top level of the sample-rate lag corrector: sequencer, shared divider, state and output register.

// Each request carries a command: a lag measurement, a sample tick or a clear of the
// synchronised flag, and yields exactly one result (correction, dwell left, sync flag,
// status). Ticks, clears and lags that are ignored or fall within the threshold finish in
// the cycle they are taken. A lag that starts a correction runs through one restoring
// divider, one quotient bit per cycle: first the tanh table index, then the dwell after an
// overflow check that saturates the dwell and skips the second division when the quotient
// would not fit; no new request is taken until its result is loaded. A lag whose tanh
// saturates skips the first division. The result waits in an output register, and a new
// request is taken while it is collected in the same cycle.
module sample_rate_lag_corrector import srlc_pkg::*;
#(
    parameter int TANH_ENTRIES = TANH_ENTRIES_DEF,
    parameter int DWELL_BITS   = DWELL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [LAG_W-1:0]   lag,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [CORR_W-1:0]  correction,
    output logic [DWELL_OUT_W-1:0]    dwell_left,
    output logic                      in_sync,
    output logic [STATUS_W-1:0]       status
);

    localparam int IDX_W  = $clog2(TANH_ENTRIES);
    localparam int PROD_W = FRAC_W + MAG_W;
    localparam int NUM1_W = MAG_W + IDX_W + 1;
    localparam int DEN1_W = SCALE_W + 2 + IDX_W - 1;
    localparam int NUM2_W = PROD_W + 2;
    localparam int DEN2_W = CODE_W + DWELL_BITS;
    localparam int DIV_A  = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
    localparam int DIV_B  = (DEN1_W > DEN2_W) ? DEN1_W : DEN2_W;
    localparam int DIV_W  = (DIV_A > DIV_B) ? DIV_A : DIV_B;
    localparam int CNT_W  = $clog2(DWELL_BITS);
    localparam logic [DWELL_BITS-1:0] DWELL_CAP = '1;

    // tanh table, one entry per index
    logic [CODE_W-1:0] tanh_rom [TANH_ENTRIES];

    for (genvar g = 0; g < TANH_ENTRIES; g++)
    begin : g_rom
        localparam longint unsigned ZARG = (longint'(g) << 30) / (2 * TANH_ENTRIES);
        localparam logic [CODE_W-1:0] ENTRY = tanh_code(ZARG);
        assign tanh_rom[g] = ENTRY;
    end

    state_t                   state_reg, state_next;
    logic [THR_W-1:0]         thr_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic [DWELL_BITS-1:0]    dwell_reg, dwell_next;
    logic signed [CORR_W-1:0] corr_reg, corr_next;
    logic                     sync_reg, sync_next;
    logic                     neg_reg, neg_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         div_reg, div_next;
    logic [DWELL_BITS-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [CORR_W-1:0] out_corr_reg;
    logic [DWELL_OUT_W-1:0]   out_dwell_reg;
    logic                     out_sync_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    logic                     load_out;
    logic [STATUS_W-1:0]      res_status;
    logic                     out_room;
    logic                     accept;
    logic [LAG_W-1:0]         lag_u;
    logic                     neg_in;
    logic [MAG_W-1:0]         mag_in;
    logic [SCALE_W+1:0]       scale4;
    logic                     start_corr;
    logic                     tanh_sat;
    logic [DIV_W:0]           diff;
    logic                     ge;
    logic signed [CORR_W-1:0] code_s;

    assign out_room = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_room;
    assign accept   = in_valid && !in_stall;

    assign lag_u   = lag;
    assign neg_in  = lag[LAG_W-1];
    assign mag_in  = neg_in ? (MAG_W'(0) - lag_u) : lag_u;
    assign scale4  = {scale_reg, 2'b00};
    assign tanh_sat = {1'b0, mag_in} >= scale4;
    assign start_corr = (cmd == CMD_LAG) && !sync_reg && (dwell_reg == '0)
                        && (mag_in > MAG_W'(thr_reg));

    // shared compare/subtract unit
    assign diff = {1'b0, rem_reg} - {1'b0, div_reg};
    assign ge   = !diff[DIV_W];
    assign code_s = $signed({1'b0, code_reg});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && start_corr)
                    state_next = tanh_sat ? ST_LOAD2 : ST_DIV1;
            end
            ST_DIV1:
            begin
                if (cnt_reg == '0)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
                state_next = ST_LOAD2;
            ST_LOAD2:
                state_next = ST_CHECK;
            ST_CHECK:
                state_next = ge ? ST_FINISH : ST_DIV2;
            ST_DIV2:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_room)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        dwell_next = dwell_reg;
        corr_next  = corr_reg;
        sync_next  = sync_reg;
        neg_next   = neg_reg;
        code_next  = code_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        res_status = STATUS_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_LAG:
                        begin
                            if (sync_reg || (dwell_reg != '0))
                            begin
                                res_status = STATUS_IGNORED;
                                load_out   = 1'b1;
                            end
                            else if (start_corr)
                            begin
                                neg_next  = neg_in;
                                prod_next = PROD_W'(frac_reg) * PROD_W'(mag_in);
                                code_next = CODE_MAX;
                                rem_next  = DIV_W'(mag_in) * DIV_W'(TANH_ENTRIES);
                                div_next  = DIV_W'(scale4) << (IDX_W - 1);
                                quo_next  = '0;
                                cnt_next  = CNT_W'(IDX_W - 1);
                            end
                            else
                            begin
                                corr_next  = '0;
                                sync_next  = 1'b1;
                                res_status = STATUS_SYNCED;
                                load_out   = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (dwell_reg != '0)
                            begin
                                dwell_next = dwell_reg - 1'b1;
                                if (dwell_reg == DWELL_BITS'(1))
                                    corr_next = '0;
                            end
                            load_out = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            sync_next = 1'b0;
                            load_out  = 1'b1;
                        end
                        default:
                            load_out = 1'b1;
                    endcase
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                if (ge)
                    rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DWELL_BITS-2:0], ge};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            ST_LOOKUP:
                code_next = tanh_rom[quo_reg[IDX_W-1:0]];
            ST_LOAD2:
            begin
                rem_next = DIV_W'({prod_reg, 2'b00});
                div_next = DIV_W'(code_reg) << DWELL_BITS;
            end
            ST_CHECK:
            begin
                // quotient would not fit: saturate
                if (ge)
                    quo_next = DWELL_CAP;
                else
                begin
                    div_next = DIV_W'(code_reg) << (DWELL_BITS - 1);
                    quo_next = '0;
                    cnt_next = CNT_W'(DWELL_BITS - 1);
                end
            end
            ST_FINISH:
            begin
                if (out_room)
                begin
                    dwell_next = quo_reg;
                    if (quo_reg == '0)
                        corr_next = '0;
                    else
                        corr_next = neg_reg ? -code_s : code_s;
                    res_status = STATUS_STARTED;
                    load_out   = 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THRESHOLD_RESET;
            scale_reg     <= SCALE_RESET;
            frac_reg      <= FRACTION_RESET;
            dwell_reg     <= '0;
            corr_reg      <= '0;
            sync_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dwell_reg     <= dwell_next;
            corr_reg      <= corr_next;
            sync_reg      <= sync_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LAG_THRESHOLD:  thr_reg   <= cfg_data[THR_W-1:0];
                    REG_TANH_SCALE:     scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_DWELL_FRACTION: frac_reg  <= cfg_data[FRAC_W-1:0];
                    default:            thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        code_reg <= code_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        if (load_out)
        begin
            out_corr_reg   <= corr_next;
            out_dwell_reg  <= DWELL_OUT_W'(dwell_next);
            out_sync_reg   <= sync_next;
            out_status_reg <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign correction = out_corr_reg;
    assign dwell_left = out_dwell_reg;
    assign in_sync    = out_sync_reg;
    assign status     = out_status_reg;

endmodule

[src/srlc_checker.sv]
// Port-level assertions for the lag corrector, bound to the top level.
module srlc_checker import srlc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [CORR_W-1:0]  correction,
    input logic [DWELL_OUT_W-1:0]    dwell_left,
    input logic                      in_sync,
    input logic [STATUS_W-1:0]       status
);

    // a held result blocks new requests, one result per request
    a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while result held");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(correction)
            && $stable(dwell_left) && $stable(in_sync) && $stable(status))
        else $error("held result changed");

    a_synced_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_SYNCED) |->
            in_sync && (correction == '0) && (dwell_left == '0))
        else $error("synchronised result inconsistent");

    a_started_not_synced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_STARTED) |-> !in_sync
            && (correction != CORR_W'(16'sh8000)))
        else $error("correction started while synchronised");

endmodule

bind sample_rate_lag_corrector srlc_checker u_srlc_checker (.*);
